// File: sv/jmsr_pkg.sv
// ----------------------------------------------------------------------------
// jmsr_pkg
// Shared types, codes and tables of the JPEG marker stream repair core.
// ----------------------------------------------------------------------------
`default_nettype none

package jmsr_pkg;

   // source formats
   localparam logic [1:0] FMT_JFIF    = 2'd0;
   localparam logic [1:0] FMT_SFW93A  = 2'd1;
   localparam logic [1:0] FMT_SFW94A  = 2'd2;
   localparam logic [1:0] FMT_PIC     = 2'd3;

   // result status codes
   localparam logic [1:0] ST_RUNNING  = 2'd0;
   localparam logic [1:0] ST_COMPLETE = 2'd1;
   localparam logic [1:0] ST_BAD      = 2'd2;
   localparam logic [1:0] ST_MISSING  = 2'd3;

   // marker bytes
   localparam logic [7:0] MK_PREFIX   = 8'hff;
   localparam logic [7:0] MK_SOI      = 8'hd8;
   localparam logic [7:0] MK_APP0     = 8'he0;
   localparam logic [7:0] MK_DHT      = 8'hc4;
   localparam logic [7:0] MK_SOS      = 8'hda;
   localparam logic [7:0] MK_EOI      = 8'hd9;
   localparam logic [7:0] MK_UNKNOWN  = 8'hfe;
   localparam logic [7:0] OBF_SOI     = 8'hc8;
   localparam logic [7:0] OBF_APP0    = 8'hd0;
   localparam logic [7:0] OBF_EOI     = 8'hc9;

   // header offsets of the forced identifier bytes
   localparam logic [3:0] HDR_START   = 4'd4;
   localparam logic [3:0] HDR_ID_LO   = 4'd6;
   localparam logic [3:0] HDR_END     = 4'd13;

   // result queue sizing
   localparam int BURST_MAX = 4;
   localparam int Q_DEPTH   = 8;
   localparam int Q_PTR_W   = $clog2(Q_DEPTH);
   localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
   localparam int N_CNT_W   = $clog2(BURST_MAX + 1);
   localparam int N_IDX_W   = $clog2(BURST_MAX);

   // configuration register index
   localparam logic CSR_SOURCE_FORMAT = 1'b0;

   // parse phase, one-hot
   typedef enum logic [8:0] {
      PH_SEARCH = 9'b000000001,
      PH_LEN_HI = 9'b000000010,
      PH_LEN_LO = 9'b000000100,
      PH_BODY   = 9'b000001000,
      PH_MARK0  = 9'b000010000,
      PH_MARK1  = 9'b000100000,
      PH_DATA   = 9'b001000000,
      PH_DONE   = 9'b010000000,
      PH_FAILED = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       insert_dqt;
      logic       insert_huffman;
      logic [1:0] status;
      logic       last;
   } result_type;

   // all results of one source byte
   typedef struct packed {
      logic [N_CNT_W-1:0]           count;
      result_type [BURST_MAX-1:0]   res;
   } step_type;

   function automatic result_type make_result(input logic [7:0] b, input logic has,
                                              input logic dqt, input logic huff,
                                              input logic [1:0] st);
      result_type r;
      r.out_byte       = b;
      r.has_byte       = has;
      r.insert_dqt     = dqt;
      r.insert_huffman = huff;
      r.status         = st;
      r.last           = 1'b0;
      return r;
   endfunction

   // forced identifier bytes at header offsets 6..12
   function automatic logic [7:0] jfif_id_byte(input logic [2:0] idx);
      logic [7:0] v;
      case (idx)
         3'd0:    v = 8'h4a;
         3'd1:    v = 8'h46;
         3'd2:    v = 8'h49;
         3'd3:    v = 8'h46;
         3'd4:    v = 8'h00;
         3'd5:    v = 8'h01;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   // obfuscated marker code translation
   function automatic logic [7:0] remap_code(input logic [7:0] c, input logic [1:0] fmt);
      logic [7:0] v;
      if (fmt != FMT_SFW94A) begin
         v = c;
      end else begin
         case (c)
            8'ha0:   v = 8'hc0;
            8'ha4:   v = 8'hc4;
            8'hc8:   v = 8'hd8;
            8'hc9:   v = 8'hd9;
            8'hca:   v = 8'hda;
            8'hcb:   v = 8'hdb;
            8'hd0:   v = 8'he0;
            default: v = MK_UNKNOWN;
         endcase
      end
      return v;
   endfunction

endpackage

`default_nettype wire

// File: sv/jmsr_parse.sv
// ----------------------------------------------------------------------------
// jmsr_parse
// Parse state and combinational step logic: one source byte in, up to four
// results out.
// ----------------------------------------------------------------------------
`default_nettype none

module jmsr_parse import jmsr_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] in_byte,
   input  wire logic       end_of_file,
   input  wire logic [1:0] source_format,
   output step_type        step
);

   phase_type   phase_ff, phase_in;
   logic [1:0]  match_ff, match_in;
   logic [3:0]  offset_ff, offset_in;
   logic [15:0] skip_ff, skip_in;
   logic [7:0]  len_hi_ff, len_hi_in;
   logic        dht_ff, dht_in;
   logic        held_ff, held_in;

   logic        hdr_active;
   logic        force_id;
   logic [7:0]  b;
   logic [7:0]  code;
   logic        sos;
   logic [7:0]  pat1, pat3, expect_byte, eoi_code;
   logic [15:0] seg_len, skip_first, skip_dec;
   logic [N_IDX_W-1:0] tail_idx;

   // header offset tracking and identifier forcing
   assign hdr_active = (phase_ff != PH_SEARCH) && (phase_ff != PH_DONE) &&
                       (phase_ff != PH_FAILED) && (offset_ff < HDR_END);
   assign force_id   = hdr_active && (offset_ff >= HDR_ID_LO) &&
                       ((source_format == FMT_SFW93A) || (source_format == FMT_SFW94A));
   assign b = force_id ? jfif_id_byte(3'(offset_ff - HDR_ID_LO)) : in_byte;

   // marker code and start pattern
   assign code     = remap_code(b, source_format);
   assign sos      = (code == MK_SOS);
   assign pat1     = (source_format == FMT_SFW94A) ? OBF_SOI  : MK_SOI;
   assign pat3     = (source_format == FMT_SFW94A) ? OBF_APP0 : MK_APP0;
   assign eoi_code = (source_format == FMT_SFW94A) ? OBF_EOI  : MK_EOI;

   always_comb begin
      case (match_ff)
         2'd0:    expect_byte = MK_PREFIX;
         2'd1:    expect_byte = pat1;
         2'd2:    expect_byte = MK_PREFIX;
         default: expect_byte = pat3;
      endcase
   end

   // segment length arithmetic
   assign seg_len    = {len_hi_ff, b};
   assign skip_first = seg_len - 16'd2;
   assign skip_dec   = skip_ff - 16'd1;

   // next state and results of one step
   always_comb begin
      phase_in  = phase_ff;
      match_in  = match_ff;
      offset_in = hdr_active ? offset_ff + 4'd1 : offset_ff;
      skip_in   = skip_ff;
      len_hi_in = len_hi_ff;
      dht_in    = dht_ff;
      held_in   = held_ff;
      step      = '0;
      tail_idx  = '0;

      unique case (phase_ff)
         PH_SEARCH: begin
            if (b == expect_byte) begin
               if (match_ff == 2'd3) begin
                  step.res[0] = make_result(MK_PREFIX, 1'b1, 1'b0, 1'b0, ST_RUNNING);
                  step.res[1] = make_result(MK_SOI,    1'b1, 1'b0, 1'b0, ST_RUNNING);
                  step.res[2] = make_result(MK_PREFIX, 1'b1, 1'b0, 1'b0, ST_RUNNING);
                  step.res[3] = make_result(MK_APP0,   1'b1, 1'b0, 1'b0, ST_RUNNING);
                  step.count  = N_CNT_W'(4);
                  match_in    = 2'd0;
                  offset_in   = HDR_START;
                  phase_in    = PH_LEN_HI;
               end else begin
                  match_in = match_ff + 2'd1;
               end
            end else if (b == MK_PREFIX) begin
               match_in = 2'd1;
            end else if ((match_ff == 2'd3) && (b == pat1)) begin
               match_in = 2'd2;
            end else begin
               match_in = 2'd0;
            end
         end
         PH_LEN_HI: begin
            len_hi_in   = b;
            step.res[0] = make_result(b, 1'b1, 1'b0, 1'b0, ST_RUNNING);
            step.count  = N_CNT_W'(1);
            phase_in    = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            step.count = N_CNT_W'(1);
            if (seg_len < 16'd2) begin
               step.res[0] = make_result(b, 1'b1, 1'b0, 1'b0, ST_BAD);
               phase_in    = PH_FAILED;
            end else begin
               step.res[0] = make_result(b, 1'b1, 1'b0, 1'b0, ST_RUNNING);
               skip_in     = skip_first;
               phase_in    = (skip_first == 16'd0) ? PH_MARK0 : PH_BODY;
            end
         end
         PH_BODY: begin
            step.res[0] = make_result(b, 1'b1, 1'b0, 1'b0, ST_RUNNING);
            step.count  = N_CNT_W'(1);
            skip_in     = skip_dec;
            if (skip_dec == 16'd0) begin
               phase_in = PH_MARK0;
            end
         end
         PH_MARK0: begin
            if (b == MK_PREFIX) begin
               held_in  = 1'b1;
               phase_in = PH_MARK1;
            end else begin
               step.res[0] = make_result(8'h00, 1'b0, 1'b0, 1'b0, ST_BAD);
               step.count  = N_CNT_W'(1);
               phase_in    = PH_FAILED;
            end
         end
         PH_MARK1: begin
            dht_in      = dht_ff | (code == MK_DHT);
            step.res[0] = make_result(MK_PREFIX, 1'b1,
                                      sos && (source_format == FMT_PIC),
                                      sos && !dht_in, ST_RUNNING);
            step.res[1] = make_result(code, 1'b1, 1'b0, 1'b0, ST_RUNNING);
            step.count  = N_CNT_W'(2);
            held_in     = 1'b0;
            phase_in    = sos ? PH_DATA : PH_LEN_HI;
         end
         PH_DATA: begin
            step.count = N_CNT_W'(1);
            if (held_ff && (b == eoi_code)) begin
               step.res[0] = make_result(MK_EOI, 1'b1, 1'b0, 1'b0, ST_COMPLETE);
               held_in     = 1'b0;
               phase_in    = PH_DONE;
            end else begin
               step.res[0] = make_result(b, 1'b1, 1'b0, 1'b0, ST_RUNNING);
               held_in     = (b == MK_PREFIX);
            end
         end
         PH_DONE, PH_FAILED: begin
         end
         default: begin
         end
      endcase

      // end of file: flag a missing start or end, then return to reset
      if (end_of_file) begin
         if ((phase_in != PH_DONE) && (phase_in != PH_FAILED)) begin
            if (step.count != '0) begin
               tail_idx                  = N_IDX_W'(step.count - N_CNT_W'(1));
               step.res[tail_idx].status = ST_MISSING;
            end else begin
               step.res[0] = make_result(8'h00, 1'b0, 1'b0, 1'b0, ST_MISSING);
               step.count  = N_CNT_W'(1);
            end
         end
         phase_in  = PH_SEARCH;
         match_in  = 2'd0;
         offset_in = 4'd0;
         skip_in   = 16'd0;
         len_hi_in = 8'd0;
         dht_in    = 1'b0;
         held_in   = 1'b0;
      end

      // mark the final result of the step
      if (step.count != '0) begin
         tail_idx                = N_IDX_W'(step.count - N_CNT_W'(1));
         step.res[tail_idx].last = 1'b1;
      end
   end

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SEARCH;
         match_ff  <= 2'd0;
         offset_ff <= 4'd0;
         skip_ff   <= 16'd0;
         len_hi_ff <= 8'd0;
         dht_ff    <= 1'b0;
         held_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         match_ff  <= match_in;
         offset_ff <= offset_in;
         skip_ff   <= skip_in;
         len_hi_ff <= len_hi_in;
         dht_ff    <= dht_in;
         held_ff   <= held_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/jmsr_rsp_queue.sv
// ----------------------------------------------------------------------------
// jmsr_rsp_queue
// Eight-entry result queue: takes a burst of up to four results per cycle
// and hands them out one per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module jmsr_rsp_queue import jmsr_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  push,
   input  step_type   step,
   input  wire logic  pop,
   output result_type head,
   output logic       not_empty,
   output logic       no_room
);

   result_type         entries_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;
   logic [Q_CNT_W-1:0] push_n;
   logic               do_pop;

   assign not_empty = (count_ff != '0);
   // room for a full burst is needed before the next source byte
   assign no_room   = (count_ff > Q_CNT_W'(Q_DEPTH - BURST_MAX));
   assign head      = entries_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   assign do_pop    = pop && not_empty;
   assign push_n    = push ? Q_CNT_W'(step.count) : '0;
   assign wr_ptr_in = wr_ptr_ff + Q_PTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + Q_PTR_W'(do_pop);
   assign count_in  = count_ff + push_n - Q_CNT_W'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // burst write into consecutive slots
   always_ff @(posedge clock) begin
      for (int i = 0; i < BURST_MAX; i++) begin
         if (push && (N_CNT_W'(i) < step.count)) begin
            entries_ff[wr_ptr_ff + Q_PTR_W'(i)] <= step.res[i];
         end
      end
   end

endmodule

`default_nettype wire

// File: sv/jpeg_marker_stream_repair_core.sv
// ----------------------------------------------------------------------------
// jpeg_marker_stream_repair_core
// Byte-stream JPEG marker repair: start pattern search, marker remapping,
// segment walk and table insertion flags.
// ----------------------------------------------------------------------------
// One source byte is accepted per cycle while req_stall is low. Each byte is
// parsed in the cycle it is accepted and yields zero to four results (four
// for the start pattern, two for a marker, none for a held marker FF), which
// enter an eight-entry result queue and leave one per rsp transaction; the
// first result of a byte is visible the cycle after acceptance if the queue
// was empty. The rsp port sets the sustained rate: one byte per cycle while
// bytes give at most one result each and rsp_stall is low, and req_stall
// rises whenever more than four results are still queued. source_format sits
// at byte address 0; the user must write it only while the block is idle
// (not enforced); end_of_file returns the parser to its search state.
`default_nettype none

module jpeg_marker_stream_repair_core import jmsr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   // source byte channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_end_of_file,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_has_byte,
   output logic             rsp_insert_dqt,
   output logic             rsp_insert_huffman,
   output logic [1:0]       rsp_status,
   output logic             rsp_last,
   // configuration port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [1:0] source_format_ff;
   logic       req_accept;
   logic       rsp_accept;
   logic       csr_write;
   step_type   step;
   result_type head;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_format_ff <= FMT_JFIF;
      end else if (csr_write && (csr_paddr[2] == CSR_SOURCE_FORMAT)) begin
         source_format_ff <= csr_pwdata[1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_SOURCE_FORMAT) begin
         csr_prdata = {30'd0, source_format_ff};
      end
   end

   // handshakes
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;

   jmsr_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .in_byte       (req_in_byte),
      .end_of_file   (req_end_of_file),
      .source_format (source_format_ff),
      .step          (step)
   );

   jmsr_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .step      (step),
      .pop       (rsp_accept),
      .head      (head),
      .not_empty (rsp_valid),
      .no_room   (req_stall)
   );

   // result fields from the queue head
   assign rsp_out_byte       = head.out_byte;
   assign rsp_has_byte       = head.has_byte;
   assign rsp_insert_dqt     = head.insert_dqt;
   assign rsp_insert_huffman = head.insert_huffman;
   assign rsp_status         = head.status;
   assign rsp_last           = head.last;

endmodule

`default_nettype wire
